### design/clle_pkg.sv
// Package for the cursor linked list engine: operation codes, error codes,
// sequencer states and default sizes. No dependencies.

package clle_pkg;

  localparam int CLLE_CAPACITY      = 256;
  localparam int CLLE_ELEMENT_WIDTH = 32;

  // Operation codes carried by the mode field
  typedef enum logic [3:0] {
    MODE_CLEAR     = 4'd0,
    MODE_SET       = 4'd1,
    MODE_FRONT     = 4'd2,
    MODE_BACK      = 4'd3,
    MODE_PREV      = 4'd4,
    MODE_NEXT      = 4'd5,
    MODE_PREPEND   = 4'd6,
    MODE_APPEND    = 4'd7,
    MODE_INSBEFORE = 4'd8,
    MODE_INSAFTER  = 4'd9,
    MODE_DELFRONT  = 4'd10,
    MODE_DELBACK   = 4'd11,
    MODE_DELCURSOR = 4'd12,
    MODE_QUERY     = 4'd13
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_EMPTY     = 2'd1,
    ERR_NO_CURSOR = 2'd2,
    ERR_FULL      = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_WR1,
    ST_WR2,
    ST_WR3,
    ST_DEL1,
    ST_DEL2,
    ST_MID1,
    ST_REL,
    ST_MOVE1,
    ST_MOVE2
  } state_t;

endpackage

### design/cursor_linked_list_engine_unit.sv
// Doubly linked list with one cursor, held in three node memories.
// Queries, clear, set, front/back moves, prev/next with no cursor or at the
// end, errors and last-element deletes raise done straight from idle; prev/next
// steps go through MOVE1 and MOVE2, end deletes through DEL1 and DEL2, a middle
// delete through MID1 and REL, inserts through WR1 to WR3 (after ALLOC when
// the node comes off the free list). A new command is taken only in idle;
// steps wait on registered link reads. The receiver cannot stall.
// Reset (rst, synchronous): empty list, no cursor, empty free list.

module cursor_linked_list_engine_unit #(
  parameter int CAPACITY      = clle_pkg::CLLE_CAPACITY,
  parameter int ELEMENT_WIDTH = clle_pkg::CLLE_ELEMENT_WIDTH,
  localparam int PW = $clog2(CAPACITY + 1),
  localparam int CW = $clog2(CAPACITY) + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [3:0]           mode,
  input  logic [31:0]          value,
  output logic                 busy,
  output logic                 done,
  output logic [1:0]           error_code,
  output logic [PW-1:0]        list_length,
  output logic signed [CW-1:0] cursor_index,
  output logic [31:0]          front_value,
  output logic [31:0]          back_value,
  output logic [31:0]          cursor_value
);
  import clle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = ELEMENT_WIDTH;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  typedef logic [PW-1:0] ptr_t;
  typedef logic [EW-1:0] elem_t;

  // Node memories
  elem_t value_mem [CAPACITY];
  ptr_t  next_mem  [CAPACITY];
  ptr_t  prev_mem  [CAPACITY];

  logic          value_we, next_we, prev_we;
  logic [AW-1:0] value_wa, next_wa, prev_wa;
  elem_t         value_wd;
  ptr_t          next_wd, prev_wd;
  logic [AW-1:0] value_ra, next_ra, prev_ra;
  elem_t         value_q;
  ptr_t          next_q, prev_q;

  // Control and list registers
  state_t state, state_next;
  mode_t  mode_r, mode_r_next;
  elem_t  val_r, val_r_next;
  ptr_t   node_n, node_n_next;
  logic   del_front, del_front_next;
  ptr_t   front, front_next, back, back_next, cur, cur_next;
  ptr_t   free_head, free_next, fresh, fresh_next, len, len_next;
  logic signed [CW-1:0] pos, pos_next;
  elem_t  fval, fval_next, bval, bval_next, cval, cval_next;
  err_t   err_r, err_next;
  logic   done_next;

  // Decode helpers
  mode_t  in_mode;
  elem_t  in_val;
  logic [EW+31:0] in_wide, fwide, bwide, cwide;
  logic   empty, has_cur;
  err_t   chk_err;
  logic   do_del, del_fr;
  ptr_t   del_node;
  ptr_t   nbr;

  assign in_mode = mode_t'(mode);
  assign in_wide = {{EW{1'b0}}, value};
  assign in_val  = in_wide[EW-1:0];
  assign empty   = (len == '0);
  assign has_cur = (cur != NIL);

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (value_we) value_mem[value_wa] <= value_wd;
    if (next_we)  next_mem[next_wa]   <= next_wd;
    if (prev_we)  prev_mem[prev_wa]   <= prev_wd;
    value_q <= value_mem[value_ra];
    next_q  <= next_mem[next_ra];
    prev_q  <= prev_mem[prev_ra];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      front     <= NIL;
      back      <= NIL;
      cur       <= NIL;
      free_head <= NIL;
      fresh     <= '0;
      len       <= '0;
      pos       <= '1;
      err_r     <= ERR_OK;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      back      <= back_next;
      cur       <= cur_next;
      free_head <= free_next;
      fresh     <= fresh_next;
      len       <= len_next;
      pos       <= pos_next;
      err_r     <= err_next;
      done      <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r    <= mode_r_next;
    val_r     <= val_r_next;
    node_n    <= node_n_next;
    del_front <= del_front_next;
    fval      <= fval_next;
    bval      <= bval_next;
    cval      <= cval_next;
  end

  // Sequencer: next state, list updates and memory accesses
  always_comb begin
    state_next     = state;
    mode_r_next    = mode_r;
    val_r_next     = val_r;
    node_n_next    = node_n;
    del_front_next = del_front;
    front_next     = front;
    back_next      = back;
    cur_next       = cur;
    free_next      = free_head;
    fresh_next     = fresh;
    len_next       = len;
    pos_next       = pos;
    fval_next      = fval;
    bval_next      = bval;
    cval_next      = cval;
    err_next       = err_r;
    done_next      = 1'b0;
    chk_err        = ERR_OK;
    do_del         = 1'b0;
    del_fr         = 1'b0;
    del_node       = front;
    nbr            = next_q;

    value_we = 1'b0;
    value_wa = cur[AW-1:0];
    value_wd = val_r;
    next_we  = 1'b0;
    next_wa  = cur[AW-1:0];
    next_wd  = NIL;
    prev_we  = 1'b0;
    prev_wa  = cur[AW-1:0];
    prev_wd  = NIL;
    value_ra = cur[AW-1:0];
    next_ra  = cur[AW-1:0];
    prev_ra  = cur[AW-1:0];

    case (state)
      ST_IDLE: begin
        // Speculative link reads for the first step of a multi-cycle op
        if (in_mode == MODE_DELFRONT) begin
          next_ra = front[AW-1:0];
        end else if (in_mode == MODE_NEXT || in_mode == MODE_DELCURSOR) begin
          next_ra = cur[AW-1:0];
        end else begin
          next_ra = free_head[AW-1:0];
        end
        prev_ra = (in_mode == MODE_DELBACK) ? back[AW-1:0] : cur[AW-1:0];

        if (start) begin
          mode_r_next = in_mode;
          val_r_next  = in_val;
          done_next   = 1'b1;
          err_next    = ERR_OK;

          // Precondition check
          if (in_mode == MODE_SET || in_mode == MODE_INSBEFORE ||
              in_mode == MODE_INSAFTER || in_mode == MODE_DELCURSOR) begin
            if (empty) chk_err = ERR_EMPTY;
            else if (!has_cur) chk_err = ERR_NO_CURSOR;
          end else if ((in_mode == MODE_DELFRONT || in_mode == MODE_DELBACK) && empty) begin
            chk_err = ERR_EMPTY;
          end

          if (chk_err != ERR_OK) begin
            err_next = chk_err;
          end else begin
            case (in_mode)
              MODE_CLEAR: begin
                // splice the chain onto the free list
                if (!empty) begin
                  next_we   = 1'b1;
                  next_wa   = back[AW-1:0];
                  next_wd   = free_head;
                  free_next = front;
                end
                front_next = NIL;
                back_next  = NIL;
                len_next   = '0;
                cur_next   = NIL;
                pos_next   = '1;
              end
              MODE_SET: begin
                value_we  = 1'b1;
                value_wa  = cur[AW-1:0];
                value_wd  = in_val;
                cval_next = in_val;
                if (cur == front) fval_next = in_val;
                if (cur == back)  bval_next = in_val;
              end
              MODE_FRONT: begin
                if (!empty) begin
                  cur_next  = front;
                  pos_next  = '0;
                  cval_next = fval;
                end
              end
              MODE_BACK: begin
                if (!empty) begin
                  cur_next  = back;
                  pos_next  = CW'(len) - CW'(1);
                  cval_next = bval;
                end
              end
              MODE_PREV: begin
                if (has_cur) begin
                  if (cur == front) begin
                    cur_next = NIL;
                    pos_next = '1;
                  end else begin
                    done_next  = 1'b0;
                    state_next = ST_MOVE1;
                  end
                end
              end
              MODE_NEXT: begin
                if (has_cur) begin
                  if (cur == back) begin
                    cur_next = NIL;
                    pos_next = '1;
                  end else begin
                    done_next  = 1'b0;
                    state_next = ST_MOVE1;
                  end
                end
              end
              MODE_PREPEND, MODE_APPEND, MODE_INSBEFORE, MODE_INSAFTER: begin
                // node from the free list first, else a fresh one
                if (free_head == NIL && fresh == NIL) begin
                  err_next = ERR_FULL;
                end else begin
                  done_next = 1'b0;
                  if (free_head != NIL) begin
                    node_n_next = free_head;
                    state_next  = ST_ALLOC;
                  end else begin
                    node_n_next = fresh;
                    fresh_next  = fresh + PW'(1);
                    state_next  = ST_WR1;
                  end
                end
              end
              MODE_DELFRONT: begin
                do_del   = 1'b1;
                del_fr   = 1'b1;
                del_node = front;
              end
              MODE_DELBACK: begin
                do_del   = 1'b1;
                del_fr   = 1'b0;
                del_node = back;
              end
              MODE_DELCURSOR: begin
                if (cur == front) begin
                  do_del   = 1'b1;
                  del_fr   = 1'b1;
                  del_node = front;
                end else if (cur == back) begin
                  do_del   = 1'b1;
                  del_fr   = 1'b0;
                  del_node = back;
                end else begin
                  node_n_next = cur;
                  done_next   = 1'b0;
                  state_next  = ST_MID1;
                end
              end
              default: ;
            endcase

            // End removal: single element finishes here
            if (do_del) begin
              if (len == PW'(1)) begin
                next_we    = 1'b1;
                next_wa    = del_node[AW-1:0];
                next_wd    = free_head;
                free_next  = del_node;
                front_next = NIL;
                back_next  = NIL;
                cur_next   = NIL;
                pos_next   = '1;
                len_next   = '0;
              end else begin
                node_n_next    = del_node;
                del_front_next = del_fr;
                done_next      = 1'b0;
                state_next     = ST_DEL1;
              end
            end
          end
        end
      end

      ST_ALLOC: begin
        free_next  = next_q;
        state_next = ST_WR1;
      end

      // New node: value and its own links
      ST_WR1: begin
        value_we = 1'b1;
        value_wa = node_n[AW-1:0];
        value_wd = val_r;
        case (mode_r)
          MODE_PREPEND: begin
            prev_we = 1'b1;
            prev_wa = node_n[AW-1:0];
            prev_wd = NIL;
            next_we = 1'b1;
            next_wa = node_n[AW-1:0];
            next_wd = front;
          end
          MODE_APPEND: begin
            next_we = 1'b1;
            next_wa = node_n[AW-1:0];
            next_wd = NIL;
            prev_we = 1'b1;
            prev_wa = node_n[AW-1:0];
            prev_wd = back;
          end
          MODE_INSBEFORE: begin
            next_we = 1'b1;
            next_wa = node_n[AW-1:0];
            next_wd = cur;
          end
          MODE_INSAFTER: begin
            prev_we = 1'b1;
            prev_wa = node_n[AW-1:0];
            prev_wd = cur;
          end
          default: ;
        endcase
        state_next = ST_WR2;
      end

      // Patch the neighbor on the far side
      ST_WR2: begin
        case (mode_r)
          MODE_PREPEND: begin
            if (!empty) begin
              prev_we = 1'b1;
              prev_wa = front[AW-1:0];
              prev_wd = node_n;
            end
          end
          MODE_APPEND: begin
            if (!empty) begin
              next_we = 1'b1;
              next_wa = back[AW-1:0];
              next_wd = node_n;
            end
          end
          MODE_INSBEFORE: begin
            prev_we = 1'b1;
            prev_wa = node_n[AW-1:0];
            prev_wd = prev_q;
            if (cur != front) begin
              next_we = 1'b1;
              next_wa = prev_q[AW-1:0];
              next_wd = node_n;
            end
          end
          MODE_INSAFTER: begin
            next_we = 1'b1;
            next_wa = node_n[AW-1:0];
            next_wd = next_q;
            if (cur != back) begin
              prev_we = 1'b1;
              prev_wa = next_q[AW-1:0];
              prev_wd = node_n;
            end
          end
          default: ;
        endcase
        state_next = ST_WR3;
      end

      // Patch the cursor node and commit the ends
      ST_WR3: begin
        len_next = len + PW'(1);
        case (mode_r)
          MODE_PREPEND: begin
            front_next = node_n;
            fval_next  = val_r;
            if (empty) begin
              back_next = node_n;
              bval_next = val_r;
            end
            if (has_cur) pos_next = pos + CW'(1);
          end
          MODE_APPEND: begin
            back_next = node_n;
            bval_next = val_r;
            if (empty) begin
              front_next = node_n;
              fval_next  = val_r;
            end
          end
          MODE_INSBEFORE: begin
            prev_we  = 1'b1;
            prev_wa  = cur[AW-1:0];
            prev_wd  = node_n;
            pos_next = pos + CW'(1);
            if (cur == front) begin
              front_next = node_n;
              fval_next  = val_r;
            end
          end
          MODE_INSAFTER: begin
            next_we = 1'b1;
            next_wa = cur[AW-1:0];
            next_wd = node_n;
            if (cur == back) begin
              back_next = node_n;
              bval_next = val_r;
            end
          end
          default: ;
        endcase
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      // End removal: unlink and fetch the new end's value
      ST_DEL1: begin
        nbr = del_front ? next_q : prev_q;
        value_ra = nbr[AW-1:0];
        if (del_front) begin
          front_next = nbr;
          prev_we    = 1'b1;
          prev_wa    = nbr[AW-1:0];
          prev_wd    = NIL;
        end else begin
          back_next = nbr;
          next_we   = 1'b1;
          next_wa   = nbr[AW-1:0];
          next_wd   = NIL;
        end
        if (cur == node_n) begin
          cur_next = NIL;
          pos_next = '1;
        end else if (del_front && has_cur) begin
          pos_next = pos - CW'(1);
        end
        len_next   = len - PW'(1);
        state_next = ST_DEL2;
      end

      ST_DEL2: begin
        next_we   = 1'b1;
        next_wa   = node_n[AW-1:0];
        next_wd   = free_head;
        free_next = node_n;
        if (del_front) fval_next = value_q;
        else bval_next = value_q;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      // Middle removal: bridge the two neighbors
      ST_MID1: begin
        next_we    = 1'b1;
        next_wa    = prev_q[AW-1:0];
        next_wd    = next_q;
        prev_we    = 1'b1;
        prev_wa    = next_q[AW-1:0];
        prev_wd    = prev_q;
        state_next = ST_REL;
      end

      ST_REL: begin
        next_we    = 1'b1;
        next_wa    = node_n[AW-1:0];
        next_wd    = free_head;
        free_next  = node_n;
        cur_next   = NIL;
        pos_next   = '1;
        len_next   = len - PW'(1);
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      // Cursor step: follow the link, then fetch the value
      ST_MOVE1: begin
        nbr      = (mode_r == MODE_PREV) ? prev_q : next_q;
        value_ra = nbr[AW-1:0];
        cur_next = nbr;
        pos_next = (mode_r == MODE_PREV) ? pos - CW'(1) : pos + CW'(1);
        state_next = ST_MOVE2;
      end

      ST_MOVE2: begin
        cval_next  = value_q;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result ports
  assign fwide = {32'b0, fval};
  assign bwide = {32'b0, bval};
  assign cwide = {32'b0, cval};

  assign busy         = (state != ST_IDLE);
  assign error_code   = err_r;
  assign list_length  = len;
  assign cursor_index = pos;
  assign front_value  = empty ? 32'b0 : fwide[31:0];
  assign back_value   = empty ? 32'b0 : bwide[31:0];
  assign cursor_value = has_cur ? cwide[31:0] : 32'b0;

endmodule

### dv/clle_checker.sv
// Scoreboard for the cursor linked list engine: watches command transfers and
// result strobes, predicts each result and compares it field by field.
// Depends on clle_pkg.
`timescale 1ns / 1ps

module clle_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [3:0]         mode,
  input  logic [31:0]        value,
  input  logic               done,
  input  logic [1:0]         error_code,
  input  logic [8:0]         list_length,
  input  logic signed [8:0]  cursor_index,
  input  logic [31:0]        front_value,
  input  logic [31:0]        back_value,
  input  logic [31:0]        cursor_value,
  output int                 fail_count,
  output int                 results_seen,
  output int                 full_errors,
  output int                 pending
);
  import clle_pkg::*;

  localparam logic [8:0] NIL = 9'd256;

  typedef struct packed {
    logic [1:0]        err;
    logic [8:0]        len;
    logic signed [8:0] cur;
    logic [31:0]       fv;
    logic [31:0]       bv;
    logic [31:0]       cv;
  } list_status_t;

  // Shadow copy of the list
  logic [31:0]       node_val [256];
  logic [8:0]        link_nxt [256];
  logic [8:0]        link_prv [256];
  logic [8:0]        head_p, tail_p, cur_p, free_p, fresh_n, elem_n;
  logic signed [8:0] cur_pos;

  list_status_t status_q[$];

  assign pending = status_q.size();

  function automatic logic [7:0] slot(input logic [8:0] p);
    return p[8] ? 8'd0 : p[7:0];
  endfunction

  task automatic drop_cursor();
    cur_p = NIL;
    cur_pos = -9'sd1;
  endtask

  task automatic free_node(input logic [8:0] n);
    link_nxt[slot(n)] = free_p;
    free_p = n;
  endtask

  task automatic unlink_head();
    logic [8:0] n;
    n = head_p;
    if (elem_n == 9'd1) begin
      head_p = NIL;
      tail_p = NIL;
      drop_cursor();
    end else begin
      head_p = link_nxt[slot(n)];
      link_prv[slot(head_p)] = NIL;
      if (cur_p == n) drop_cursor();
      else if (cur_p != NIL) cur_pos = cur_pos - 9'sd1;
    end
    elem_n = elem_n - 9'd1;
    free_node(n);
  endtask

  task automatic unlink_tail();
    logic [8:0] n;
    n = tail_p;
    if (elem_n == 9'd1) begin
      head_p = NIL;
      tail_p = NIL;
      drop_cursor();
    end else begin
      tail_p = link_prv[slot(n)];
      link_nxt[slot(tail_p)] = NIL;
      if (cur_p == n) drop_cursor();
    end
    elem_n = elem_n - 9'd1;
    free_node(n);
  endtask

  task automatic clear_list();
    for (int i = 0; i < 256; i++) begin
      node_val[i] = '0;
      link_nxt[i] = '0;
      link_prv[i] = '0;
    end
    head_p = NIL;
    tail_p = NIL;
    cur_p = NIL;
    free_p = NIL;
    fresh_n = '0;
    elem_n = '0;
    cur_pos = -9'sd1;
  endtask

  // Apply one operation to the shadow list and return the status it reports
  task automatic apply_op(input logic [3:0] m, input logic [31:0] v,
                          output list_status_t r);
    logic [1:0] err;
    logic       empty, has_cur;
    logic [8:0] n;
    logic [7:0] c;
    err = ERR_OK;
    empty = (elem_n == 9'd0);
    has_cur = (cur_p != NIL);
    if (m == MODE_SET || m == MODE_INSBEFORE || m == MODE_INSAFTER ||
        m == MODE_DELCURSOR) begin
      if (empty) err = ERR_EMPTY;
      else if (!has_cur) err = ERR_NO_CURSOR;
    end else if ((m == MODE_DELFRONT || m == MODE_DELBACK) && empty) begin
      err = ERR_EMPTY;
    end
    if (err == ERR_OK) begin
      c = slot(cur_p);
      case (m)
        MODE_CLEAR: begin
          if (!empty) begin
            link_nxt[slot(tail_p)] = free_p;
            free_p = head_p;
          end
          head_p = NIL;
          tail_p = NIL;
          elem_n = '0;
          drop_cursor();
        end
        MODE_SET: node_val[c] = v;
        MODE_FRONT: if (!empty) begin
          cur_p = head_p;
          cur_pos = '0;
        end
        MODE_BACK: if (!empty) begin
          cur_p = tail_p;
          cur_pos = $signed(elem_n - 9'd1);
        end
        MODE_PREV: if (has_cur) begin
          if (cur_p == head_p) drop_cursor();
          else begin
            cur_p = link_prv[c];
            cur_pos = cur_pos - 9'sd1;
          end
        end
        MODE_NEXT: if (has_cur) begin
          if (cur_p == tail_p) drop_cursor();
          else begin
            cur_p = link_nxt[c];
            cur_pos = cur_pos + 9'sd1;
          end
        end
        MODE_PREPEND, MODE_APPEND, MODE_INSBEFORE, MODE_INSAFTER: begin
          // free list first, then never-used nodes
          if (free_p != NIL) begin
            n = free_p;
            free_p = link_nxt[slot(n)];
          end else if (fresh_n < NIL) begin
            n = fresh_n;
            fresh_n = fresh_n + 9'd1;
          end else begin
            n = NIL;
          end
          if (n == NIL) begin
            err = ERR_FULL;
          end else begin
            node_val[n[7:0]] = v;
            if (m == MODE_PREPEND) begin
              link_prv[n[7:0]] = NIL;
              link_nxt[n[7:0]] = head_p;
              if (empty) tail_p = n;
              else link_prv[slot(head_p)] = n;
              head_p = n;
              if (has_cur) cur_pos = cur_pos + 9'sd1;
            end else if (m == MODE_APPEND) begin
              link_nxt[n[7:0]] = NIL;
              link_prv[n[7:0]] = tail_p;
              if (empty) head_p = n;
              else link_nxt[slot(tail_p)] = n;
              tail_p = n;
            end else if (m == MODE_INSBEFORE) begin
              link_nxt[n[7:0]] = cur_p;
              link_prv[n[7:0]] = link_prv[c];
              if (cur_p == head_p) head_p = n;
              else link_nxt[slot(link_prv[c])] = n;
              link_prv[c] = n;
              cur_pos = cur_pos + 9'sd1;
            end else begin
              link_prv[n[7:0]] = cur_p;
              link_nxt[n[7:0]] = link_nxt[c];
              if (cur_p == tail_p) tail_p = n;
              else link_prv[slot(link_nxt[c])] = n;
              link_nxt[c] = n;
            end
            elem_n = elem_n + 9'd1;
          end
        end
        MODE_DELFRONT: unlink_head();
        MODE_DELBACK: unlink_tail();
        MODE_DELCURSOR: begin
          if (cur_p == head_p) unlink_head();
          else if (cur_p == tail_p) unlink_tail();
          else begin
            link_nxt[slot(link_prv[c])] = link_nxt[c];
            link_prv[slot(link_nxt[c])] = link_prv[c];
            free_node(cur_p);
            drop_cursor();
            elem_n = elem_n - 9'd1;
          end
        end
        default: ;
      endcase
    end
    r.err = err;
    r.len = elem_n;
    r.cur = cur_pos;
    r.fv  = (elem_n != 9'd0) ? node_val[slot(head_p)] : '0;
    r.bv  = (elem_n != 9'd0) ? node_val[slot(tail_p)] : '0;
    r.cv  = (cur_p != NIL) ? node_val[slot(cur_p)] : '0;
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    full_errors = 0;
    clear_list();
  end

  // Compare results first, then predict the command taken at this edge
  always @(posedge clk) begin
    list_status_t want, got;
    if (rst) begin
      clear_list();
      status_q.delete();
    end else begin
      if (done) begin
        got = '{error_code, list_length, cursor_index,
                front_value, back_value, cursor_value};
        results_seen++;
        if (error_code == ERR_FULL) full_errors++;
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: result with no pending command");
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: exp err=%0d len=%0d cur=%0d f=%h b=%h c=%h | got err=%0d len=%0d cur=%0d f=%h b=%h c=%h",
                       want.err, want.len, want.cur, want.fv, want.bv, want.cv,
                       got.err, got.len, got.cur, got.fv, got.bv, got.cv);
          end
        end
      end
      if (start && !busy) begin
        apply_op(mode, value, want);
        status_q.push_back(want);
      end
    end
  end

endmodule

### dv/tb_cursor_linked_list_engine_unit.sv
// Testbench top for cursor_linked_list_engine_unit: clock, reset, directed and
// random command stimulus, verdict. Depends on clle_pkg and clle_checker.
`timescale 1ns / 1ps

module tb_cursor_linked_list_engine_unit;
  import clle_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [3:0]        mode = '0;
  logic [31:0]       value = '0;
  logic              busy, done;
  logic [1:0]        error_code;
  logic [8:0]        list_length;
  logic signed [8:0] cursor_index;
  logic [31:0]       front_value, back_value, cursor_value;
  int                fail_count, results_seen, full_errors, pending;
  int                cycles = 0;
  int                cmds_sent = 0;

  cursor_linked_list_engine_unit uut (
    .clk, .rst, .start, .mode, .value, .busy, .done, .error_code,
    .list_length, .cursor_index, .front_value, .back_value, .cursor_value
  );

  clle_checker chk (
    .clk, .rst, .start, .busy, .mode, .value, .done, .error_code,
    .list_length, .cursor_index, .front_value, .back_value, .cursor_value,
    .fail_count, .results_seen, .full_errors, .pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cursor_linked_list_engine_unit verification failed");
      $finish;
    end
  end

  // Present one command and hold it until the transfer, then maybe idle
  task automatic issue(input logic [3:0] m, input logic [31:0] v);
    int gap, r;
    start <= 1'b1;
    mode  <= m;
    value <= v;
    do @(posedge clk); while (busy);
    cmds_sent++;
    r = $urandom_range(99);
    if (r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(3, 1);
    else gap = $urandom_range(40, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_elem();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Operation mix per phase: 0 grow, 1 shrink, 2 mixed
  function automatic logic [3:0] pick_mode(input int phase);
    int r;
    r = $urandom_range(99);
    case (phase)
      0: begin
        if (r < 85) return 4'($urandom_range(MODE_INSAFTER, MODE_PREPEND));
        if (r < 95) return 4'($urandom_range(MODE_NEXT, MODE_FRONT));
        if (r < 97) return MODE_SET;
        return 4'($urandom_range(MODE_DELCURSOR, MODE_DELFRONT));
      end
      1: begin
        if (r < 60) return 4'($urandom_range(MODE_DELCURSOR, MODE_DELFRONT));
        if (r < 85) return 4'($urandom_range(MODE_NEXT, MODE_FRONT));
        if (r < 92) return 4'($urandom_range(MODE_INSAFTER, MODE_PREPEND));
        return 4'($urandom_range(15, MODE_QUERY));
      end
      default: begin
        if (r < 2) return MODE_CLEAR;
        return 4'($urandom_range(15, 1));
      end
    endcase
  endfunction

  task automatic run_phase(input int phase, input int count);
    for (int i = 0; i < count; i++) issue(pick_mode(phase), rand_elem());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-list corners, end moves, inserts at both ends
    issue(MODE_CLEAR, '0);
    issue(MODE_QUERY, '0);
    issue(MODE_FRONT, '0);
    issue(MODE_BACK, '0);
    issue(MODE_PREV, '0);
    issue(MODE_NEXT, '0);
    issue(MODE_SET, 32'h1);
    issue(MODE_INSBEFORE, 32'h2);
    issue(MODE_DELCURSOR, '0);
    issue(MODE_DELFRONT, '0);
    issue(MODE_DELBACK, '0);
    issue(MODE_APPEND, 32'hFFFF_FFFF);
    issue(MODE_SET, 32'h5);
    issue(MODE_PREPEND, 32'h0);
    issue(MODE_APPEND, 32'hA5A5_5A5A);
    issue(MODE_FRONT, '0);
    issue(MODE_PREV, '0);
    issue(MODE_BACK, '0);
    issue(MODE_NEXT, '0);
    issue(MODE_FRONT, '0);
    issue(MODE_INSBEFORE, 32'h1234_5678);
    issue(MODE_NEXT, '0);
    issue(MODE_INSAFTER, 32'h8765_4321);
    issue(MODE_DELCURSOR, '0);
    issue(4'd14, '0);
    issue(4'd15, '0);

    // Random: fill past capacity, churn, drain, refill from free list, churn
    run_phase(0, 350);
    run_phase(2, 150);
    run_phase(1, 200);
    run_phase(0, 300);
    run_phase(2, 100);

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d commands, %0d results checked, %0d store-full answers.",
             cmds_sent, results_seen, full_errors);
    if (fail_count == 0 && pending == 0) begin
      $display("cursor_linked_list_engine_unit verification clean");
    end else begin
      $display("cursor_linked_list_engine_unit verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/clle_pkg.sv
design/cursor_linked_list_engine_unit.sv
dv/clle_checker.sv
dv/tb_cursor_linked_list_engine_unit.sv
